// ----- rtl/rhc_pkg.sv -----
// Shared constants and types for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

  localparam int unsigned CHAN_W = 8;   // one color channel
  localparam int unsigned PIXEL_W = 24; // packed R, G, B
  localparam int unsigned HUE_W = 16;
  localparam int unsigned SAT_W = 16;
  localparam int unsigned HDIV_W = 11;  // 6 * chroma, at most 1530

  localparam logic [HUE_W-1:0] HUE_MAX = '1;
  localparam logic [SAT_W-1:0] SAT_MAX = '1;

  // Hue offset in sixths of a turn, set by the channel swaps
  typedef enum logic [1:0] {
    SEC_ZERO = 2'd0, // no swap: offset 0
    SEC_NEG6 = 2'd1, // green/blue swapped: offset -6
    SEC_NEG2 = 2'd2, // red/green swapped only: offset -2
    SEC_POS4 = 2'd3  // both swapped: offset +4
  } hue_sector_e;

endpackage : rhc_pkg

`default_nettype wire

// ----- rtl/rgb_to_hsv_convert.sv -----
// RGB to HSV converter: pipelined swap-and-offset hue with restoring dividers.
`default_nettype none

// Converts one packed 24-bit RGB pixel per transfer into hue, saturation and
// value. Throughput is one pixel per clock while the output is not stalled.
// The first stage sorts the channels with two conditional swaps, forms chroma
// and the hue numerator; FRACTION_BITS + 1 stages then each produce one
// quotient bit of two restoring dividers running side by side (hue numerator
// over 6 * chroma, chroma over the largest channel); the last stage fixes up
// the saturation quotient, clamps both results to 16 bits and holds the
// output. Hue is a fraction of a full turn scaled by 2^FRACTION_BITS,
// saturation is scaled by 2^FRACTION_BITS - 1, and value is the largest
// channel byte. A gray pixel gives hue 0, a black one gives hue and
// saturation 0. Valid bits travel with the data; a stage that is empty takes
// a new item even while a later stage is stalled, so bubbles are squeezed
// out and stall only reaches the input when every stage holds an item.
module rgb_to_hsv_convert
  import rhc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PIXEL_W-1:0] pixel_rgb_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [HUE_W-1:0]        hue_o,
  output logic [SAT_W-1:0]        saturation_o,
  output logic [CHAN_W-1:0]       brightness_o
);

  // Quotient bits: one integer bit plus the fraction
  localparam int unsigned QW = FRACTION_BITS + 1;
  // Division stages, and all stages including prep and output
  localparam int unsigned NSTEP = QW;
  localparam int unsigned NS = NSTEP + 2;
  // Width used to compare a quotient against the 16-bit limit
  localparam int unsigned EW = QW + HUE_W;

  // ---------------------------------------------------------------------
  // Stage registers, indexed by stage: 0 is the prep stage, k holds the
  // state after k division steps, NS-1 is the output register.
  // ---------------------------------------------------------------------
  logic                 valid_q [NS];
  logic                 rdy     [NS+1];

  logic [HDIV_W-1:0]    h_rem_q [NSTEP+1];
  logic [HDIV_W-1:0]    h_div_q [NSTEP+1];
  logic [QW-1:0]        h_quo_q [NSTEP+1];
  logic [CHAN_W-1:0]    s_rem_q [NSTEP+1];
  logic [CHAN_W-1:0]    s_div_q [NSTEP+1];
  logic [QW-1:0]        s_quo_q [NSTEP+1];
  logic [CHAN_W-1:0]    chroma_q[NSTEP+1];
  logic                 gray_q  [NSTEP+1];
  logic                 black_q [NSTEP+1];

  // A stage advances when it is empty or its successor advances
  assign rdy[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_ready
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Prep stage: sort channels, track the hue offset, form chroma, the hue
  // numerator |K6 * chroma + (g - b)| and the divisor 6 * chroma.
  // ---------------------------------------------------------------------
  logic [CHAN_W-1:0] r0, g0, b0;
  logic [CHAN_W-1:0] g1, b1, r2, g2, lo;
  logic              swap_gb, swap_rg;
  hue_sector_e       sector;
  logic [CHAN_W-1:0] chroma_d;
  logic [HDIV_W-1:0] six_c;
  logic [12:0]       offs, diff, sum;
  logic [12:0]       mag;

  always_comb begin
    r0 = pixel_rgb_i[23:16];
    g0 = pixel_rgb_i[15:8];
    b0 = pixel_rgb_i[7:0];

    swap_gb = g0 < b0;
    g1      = swap_gb ? b0 : g0;
    b1      = swap_gb ? g0 : b0;
    swap_rg = r0 < g1;
    r2      = swap_rg ? g1 : r0;
    g2      = swap_rg ? r0 : g1;
    lo      = (g2 < b1) ? g2 : b1;

    case ({swap_gb, swap_rg})
      2'b00:   sector = SEC_ZERO;
      2'b10:   sector = SEC_NEG6;
      2'b01:   sector = SEC_NEG2;
      default: sector = SEC_POS4;
    endcase

    chroma_d = r2 - lo;
    six_c    = {1'b0, chroma_d, 2'b00} + {2'b00, chroma_d, 1'b0};

    case (sector)
      SEC_ZERO: offs = '0;
      SEC_NEG6: offs = 13'(-$signed({2'b00, six_c}));
      SEC_NEG2: offs = 13'(-$signed({4'b0000, chroma_d, 1'b0}));
      SEC_POS4: offs = {3'b000, chroma_d, 2'b00};
      default:  offs = '0;
    endcase

    diff = 13'($signed({1'b0, g2}) - $signed({1'b0, b1}));
    sum  = offs + diff;
    mag  = sum[12] ? 13'(-$signed(sum)) : sum;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      h_rem_q[0]  <= mag[HDIV_W-1:0];
      h_div_q[0]  <= six_c;
      h_quo_q[0]  <= '0;
      s_rem_q[0]  <= chroma_d;
      s_div_q[0]  <= r2;
      s_quo_q[0]  <= '0;
      chroma_q[0] <= chroma_d;
      gray_q[0]   <= (chroma_d == '0);
      black_q[0]  <= (r2 == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Division stages: one restoring step per stage for each divider. The
  // first step compares the unshifted remainder to get the integer bit.
  // ---------------------------------------------------------------------
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [HDIV_W:0]   h_trial;
    logic [HDIV_W:0]   h_sub;
    logic              h_ge;
    logic [CHAN_W:0]   s_trial;
    logic [CHAN_W:0]   s_sub;
    logic              s_ge;

    always_comb begin
      if (k == 1) begin
        h_trial = {1'b0, h_rem_q[k-1]};
        s_trial = {1'b0, s_rem_q[k-1]};
      end else begin
        h_trial = {h_rem_q[k-1], 1'b0};
        s_trial = {s_rem_q[k-1], 1'b0};
      end
      h_ge  = h_trial >= {1'b0, h_div_q[k-1]};
      h_sub = h_trial - {1'b0, h_div_q[k-1]};
      s_ge  = s_trial >= {1'b0, s_div_q[k-1]};
      s_sub = s_trial - {1'b0, s_div_q[k-1]};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        h_rem_q[k]  <= h_ge ? h_sub[HDIV_W-1:0] : h_trial[HDIV_W-1:0];
        h_div_q[k]  <= h_div_q[k-1];
        h_quo_q[k]  <= {h_quo_q[k-1][QW-2:0], h_ge};
        s_rem_q[k]  <= s_ge ? s_sub[CHAN_W-1:0] : s_trial[CHAN_W-1:0];
        s_div_q[k]  <= s_div_q[k-1];
        s_quo_q[k]  <= {s_quo_q[k-1][QW-2:0], s_ge};
        chroma_q[k] <= chroma_q[k-1];
        gray_q[k]   <= gray_q[k-1];
        black_q[k]  <= black_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage. The saturation divider found floor(chroma * 2^F / r);
  // the wanted floor(chroma * (2^F - 1) / r) is one less exactly when the
  // final remainder is below chroma. Clamp both results to 16 bits.
  // ---------------------------------------------------------------------
  logic [EW-1:0]     hue_ext, sat_ext;
  logic [QW-1:0]     sat_adj;
  logic [HUE_W-1:0]  hue_d;
  logic [SAT_W-1:0]  sat_d;
  logic [HUE_W-1:0]  hue_q;
  logic [SAT_W-1:0]  sat_q;
  logic [CHAN_W-1:0] bright_q;

  always_comb begin
    sat_adj = s_quo_q[NSTEP] - QW'(s_rem_q[NSTEP] < chroma_q[NSTEP]);
    hue_ext = EW'(h_quo_q[NSTEP]);
    sat_ext = EW'(sat_adj);

    if (gray_q[NSTEP]) begin
      hue_d = '0;
    end else if (hue_ext > EW'(HUE_MAX)) begin
      hue_d = HUE_MAX;
    end else begin
      hue_d = hue_ext[HUE_W-1:0];
    end

    if (black_q[NSTEP]) begin
      sat_d = '0;
    end else if (sat_ext > EW'(SAT_MAX)) begin
      sat_d = SAT_MAX;
    end else begin
      sat_d = sat_ext[SAT_W-1:0];
    end
  end

  // Hold while stalled; load only when the output register may advance
  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= s_div_q[NSTEP];
    end
  end

  assign out_valid_o  = valid_q[NS-1];
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule : rgb_to_hsv_convert

`default_nettype wire

// ----- rtl/rhc_check.sv -----
// Port-level checks for the RGB to HSV converter, bound to the top level.
`default_nettype none

module rhc_check
  import rhc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [PIXEL_W-1:0] pixel_rgb_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [HUE_W-1:0]   hue_o,
  input wire logic [SAT_W-1:0]   saturation_o,
  input wire logic [CHAN_W-1:0]  brightness_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ (^pixel_rgb_i);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o))
    else $error("stalled output changed");

  // An empty output register means nothing upstream can be blocked
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Black pixel: no hue, no saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (brightness_o == '0) |-> (saturation_o == '0) && (hue_o == '0))
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation means zero chroma, so the hue must be zero
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (saturation_o == '0) |-> (hue_o == '0))
    else $error("gray pixel with nonzero hue");

endmodule : rhc_check

bind rgb_to_hsv_convert rhc_check u_rhc_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .pixel_rgb_i  (pixel_rgb_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .brightness_o (brightness_o)
);

`default_nettype wire
